// ===== design/lzssbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lzssbd_pkg;

	localparam int TOK_MAX_W = 18;
	localparam logic [7:0] SPACE_BYTE = 8'h20;

	typedef enum logic [1:0] {
		TOK_NONE  = 2'd0,
		TOK_LIT   = 2'd1,
		TOK_MATCH = 2'd2
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t              kind;
		logic [TOK_MAX_W-1:0]   body;
	} tok_cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} out_item_t;

endpackage
`default_nettype wire

// ===== design/lzssbd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzssbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/lzssbd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzssbd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic                            full,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           rdata,
	output logic                            empty,
	output logic      [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== design/lzssbd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzssbd_front
	import lzssbd_pkg::*;
#(
	parameter int WINDOW_BITS = 9,
	parameter int LENGTH_BITS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	output tok_cmd_t        cmd
);

	localparam int ACC_W = WINDOW_BITS + LENGTH_BITS;
	localparam int LW    = $clog2(ACC_W + 1);

	typedef enum logic [2:0] {
		PH_FLAG  = 3'b001,
		PH_LIT   = 3'b010,
		PH_MATCH = 3'b100
	} phase_t;

	phase_t           phase_q;
	logic [LW-1:0]    left_q;
	logic [ACC_W-1:0] acc_q;

	phase_t           phase_n;
	logic [LW-1:0]    left_n;
	logic [ACC_W-1:0] acc_n;

	// walk the eight bits, msb first; at most one token closes per byte
	always_comb begin
		phase_n  = phase_q;
		left_n   = left_q;
		acc_n    = acc_q;
		cmd.kind = TOK_NONE;
		cmd.body = '0;
		for (int i = 7; i >= 0; i--) begin
			unique case (phase_n) inside
				PH_FLAG: begin
					acc_n = '0;
					if (in_byte[i]) begin
						phase_n = PH_LIT;
						left_n  = LW'(8);
					end else begin
						phase_n = PH_MATCH;
						left_n  = LW'(ACC_W);
					end
				end
				PH_LIT, PH_MATCH: begin
					acc_n = {acc_n[ACC_W-2:0], in_byte[i]};
					if (left_n != '0) begin
						left_n = left_n - LW'(1);
					end
					if (left_n == '0) begin
						cmd.kind = (phase_n == PH_LIT) ? TOK_LIT : TOK_MATCH;
						cmd.body = TOK_MAX_W'(acc_n);
						phase_n  = PH_FLAG;
						acc_n    = '0;
					end
				end
				default: begin
					phase_n = PH_FLAG;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			left_q  <= '0;
			acc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			left_q  <= left_n;
			acc_q   <= acc_n;
		end
	end

endmodule
`default_nettype wire

// ===== design/lzssbd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzssbd_back
	import lzssbd_pkg::*;
#(
	parameter int WINDOW_BITS = 9,
	parameter int LENGTH_BITS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] total_size,
	input  tok_cmd_t         cmd,
	input  wire logic        cmd_empty,
	output logic             cmd_pop,
	output logic             clearing,
	input  wire logic        pop,
	output logic             empty,
	output logic      [7:0]  out_byte,
	output logic             run_last,
	output logic             stream_done
);

	localparam int ACC_W    = WINDOW_BITS + LENGTH_BITS;
	localparam int RING     = 1 << WINDOW_BITS;
	localparam int AW       = WINDOW_BITS;
	localparam int FILL_END = RING - (1 << LENGTH_BITS) - 1;
	localparam int LW       = LENGTH_BITS + 1;
	localparam int OF_DEPTH = 4;
	localparam int OCW      = $clog2(OF_DEPTH + 1);

	typedef enum logic [2:0] {
		B_CLEAR = 3'b001,
		B_IDLE  = 3'b010,
		B_COPY  = 3'b100
	} bstate_t;

	bstate_t       state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] wi_q;
	logic [AW-1:0] rd_q;
	logic [LW-1:0] k_q;
	logic [LW-1:0] lenm1_q;
	logic [31:0]   cnt_q;
	logic          fin_q;

	logic          v_s1;
	logic          lit_s1;
	logic [7:0]    litb_s1;
	logic          last_s1;
	logic          done_s1;
	logic          byp_s1;
	logic [7:0]    bypd_s1;

	logic [7:0]    ram_rd;
	logic [7:0]    wr_data;
	logic          ram_we;
	logic [AW-1:0] ram_wa;
	logic [7:0]    ram_wd;

	logic [OCW-1:0] of_cnt;
	logic           of_full;
	logic           credit;
	logic [32:0]    cnt_inc;
	logic           reach;
	logic           spent;
	logic           lit_go;
	logic           match_go;
	logic           copy_go;
	logic           copy_last;
	logic           issue;
	out_item_t      of_in;
	out_item_t      of_out;

	assign clearing  = (state_q == B_CLEAR);
	assign credit    = (of_cnt + OCW'(v_s1)) < OCW'(OF_DEPTH);
	assign cnt_inc   = {1'b0, cnt_q} + 33'd1;
	assign reach     = (cnt_inc >= {1'b0, total_size});
	assign spent     = (cnt_q >= total_size);
	assign cmd_pop   = (state_q == B_IDLE) && !cmd_empty && credit;
	assign lit_go    = cmd_pop && !fin_q && !spent && (cmd.kind == TOK_LIT);
	assign match_go  = cmd_pop && !fin_q && !spent && (cmd.kind == TOK_MATCH);
	assign copy_go   = (state_q == B_COPY) && credit;
	assign copy_last = (k_q == lenm1_q) || reach;
	assign issue     = lit_go || copy_go;

	// a copy may read the byte written in the same cycle
	assign wr_data = lit_s1 ? litb_s1 : (byp_s1 ? bypd_s1 : ram_rd);

	assign ram_we = clearing || v_s1;
	assign ram_wa = clearing ? clr_q : wi_q;
	assign ram_wd = clearing ? ((clr_q < AW'(FILL_END)) ? SPACE_BYTE : 8'h00) : wr_data;

	lzssbd_ram #(
		.WIDTH(8),
		.DEPTH(RING)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.raddr(rd_q),
		.rdata(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			wi_q    <= AW'(FILL_END);
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (v_s1) begin
				wi_q <= wi_q + AW'(1);
			end
			if (issue) begin
				cnt_q <= cnt_q + 32'd1;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(RING - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (cmd_pop) begin
						if (fin_q || spent) begin
							fin_q <= 1'b1;
						end else if (lit_go && reach) begin
							fin_q <= 1'b1;
						end else if (match_go) begin
							state_q <= B_COPY;
						end
					end
				end
				B_COPY: begin
					if (copy_go) begin
						if (reach) begin
							fin_q <= 1'b1;
						end
						if (copy_last) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (match_go) begin
			rd_q    <= cmd.body[ACC_W-1:LENGTH_BITS];
			k_q     <= '0;
			lenm1_q <= {1'b0, cmd.body[LENGTH_BITS-1:0]} + LW'(1);
		end else if (copy_go) begin
			rd_q <= rd_q + AW'(1);
			k_q  <= k_q + LW'(1);
		end
		lit_s1  <= lit_go;
		litb_s1 <= cmd.body[7:0];
		last_s1 <= lit_go || copy_last;
		done_s1 <= reach;
		byp_s1  <= v_s1 && (wi_q == rd_q);
		bypd_s1 <= wr_data;
	end

	assign of_in = '{data: wr_data, last: last_s1, done: done_s1};

	lzssbd_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OF_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (v_s1),
		.wdata (of_in),
		.full  (of_full),
		.pop   (pop),
		.rdata (of_out),
		.empty (empty),
		.count (of_cnt)
	);

	assign out_byte    = of_out.data;
	assign run_last    = of_out.last;
	assign stream_done = of_out.done;

`ifndef SYNTHESIS
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n) v_s1 |-> !of_full)
		else $error("output queue overrun");
	a_fin_quiet: assert property (@(posedge clk) disable iff (!arst_n) fin_q |=> !v_s1)
		else $error("byte issued after end of stream");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> !v_s1 && !cmd_pop)
		else $error("activity during ring clear");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && done_s1) |-> last_s1)
		else $error("final byte not marked last");
`endif

endmodule
`default_nettype wire

// ===== design/lzss_bit_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// LZSS bit-stream decoder. Compressed bytes enter through push/full and are
// parsed into tokens at one byte per cycle while full is low; the tokens wait
// in a four-entry queue, and decoded bytes leave through empty/pop, each with
// run_last and stream_done. The copy engine turns out one decoded byte per
// cycle while the output queue has room, bounded by the single read port of
// the ring memory. Every queue entry is popped, also one from an input byte
// that closes no token; a match copies up to 2^LENGTH_BITS + 1 bytes. After
// reset the ring (2^WINDOW_BITS bytes, 512 by default) is filled, during which
// full stays high. total_size may only be written while the decoder is idle.
module lzss_bit_decoder_core
	import lzssbd_pkg::*;
#(
	parameter int WINDOW_BITS = 9,
	parameter int LENGTH_BITS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic      [7:0]  out_byte,
	output logic             run_last,
	output logic             stream_done,
	input  wire logic        total_size_we,
	input  wire logic [31:0] total_size
);

	localparam int CMD_DEPTH = 4;

	logic [31:0] total_size_q;
	logic        accept;
	logic        cmd_full;
	logic        cmd_empty;
	logic        cmd_pop;
	logic        clearing;
	tok_cmd_t    cmd_in;
	tok_cmd_t    cmd_out;

	assign full   = cmd_full || clearing;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_size_q <= '0;
		end else if (total_size_we) begin
			total_size_q <= total_size;
		end
	end

	lzssbd_front #(
		.WINDOW_BITS(WINDOW_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.in_byte(in_byte),
		.cmd    (cmd_in)
	);

	lzssbd_fifo #(
		.WIDTH($bits(tok_cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty),
		.count ()
	);

	lzssbd_back #(
		.WINDOW_BITS(WINDOW_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.total_size (total_size_q),
		.cmd        (cmd_out),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.clearing   (clearing),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.stream_done(stream_done)
	);

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import lzssbd_pkg::*;

	localparam int WB = 9;
	localparam int LB = 4;
	localparam int RING = 1 << WB;
	localparam int FILL_END = RING - (1 << LB) - 1;
	localparam int SETTLE = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int WD_LIMIT = 4000;

	class decode_scoreboard;
		logic [7:0]    ring [RING];
		logic [WB-1:0] wr_ptr;
		tok_kind_t     phase;
		logic [3:0]    bits_left;
		logic [12:0]   accum;
		logic [31:0]   emitted;
		logic [31:0]   total;
		bit            done;
		out_item_t     pending_bytes[$];
		int            errors;

		function new();
			for (int i = 0; i < RING; i++) begin
				ring[i] = (i < FILL_END) ? SPACE_BYTE : 8'h00;
			end
			wr_ptr = WB'(FILL_END);
			phase = TOK_NONE;
			bits_left = '0;
			accum = '0;
			emitted = '0;
			total = '0;
			done = 1'b0;
			errors = 0;
		endfunction

		function void set_total(input logic [31:0] v);
			total = v;
		endfunction

		function void put_decoded(input logic [7:0] d, inout int n);
			out_item_t it;
			ring[wr_ptr] = d;
			wr_ptr = wr_ptr + 1'b1;
			emitted = emitted + 1;
			it.data = d;
			it.last = 1'b0;
			it.done = 1'b0;
			if (emitted >= total) begin
				done = 1'b1;
				it.done = 1'b1;
			end
			pending_bytes.push_back(it);
			n++;
		endfunction

		// one compressed byte in, decoded bytes onto the pending list
		function void decode_byte(input logic [7:0] b);
			int            n;
			logic          bitv;
			logic [WB-1:0] rd;
			logic [4:0]    len;
			out_item_t     it;
			n = 0;
			if (done || emitted >= total) begin
				done = 1'b1;
				return;
			end
			for (int i = 7; i >= 0 && !done; i--) begin
				bitv = b[i];
				if (phase == TOK_NONE) begin
					accum = '0;
					phase = bitv ? TOK_LIT : TOK_MATCH;
					bits_left = bitv ? 4'd8 : 4'(WB + LB);
					continue;
				end
				accum = {accum[11:0], bitv};
				bits_left = bits_left - 1'b1;
				if (bits_left != 0)
					continue;
				if (phase == TOK_LIT) begin
					put_decoded(accum[7:0], n);
				end else begin
					rd = accum[WB+LB-1:LB];
					len = {1'b0, accum[LB-1:0]} + 5'd2;
					for (int k = 0; k < len && !done; k++) begin
						put_decoded(ring[rd], n);
						rd = rd + 1'b1;
					end
				end
				phase = TOK_NONE;
				accum = '0;
			end
			if (n > 0) begin
				it = pending_bytes.pop_back();
				it.last = 1'b1;
				pending_bytes.push_back(it);
			end
		endfunction

		function void match_output(input logic [7:0] d, input logic l, input logic s);
			out_item_t e;
			if (pending_bytes.size() == 0) begin
				$error("out_byte: nothing expected, got %02h", d);
				errors++;
				return;
			end
			e = pending_bytes.pop_front();
			if (d !== e.data) begin
				$error("out_byte: expected %02h, got %02h", e.data, d);
				errors++;
			end
			if (l !== e.last) begin
				$error("run_last: expected %0b, got %0b", e.last, l);
				errors++;
			end
			if (s !== e.done) begin
				$error("stream_done: expected %0b, got %0b", e.done, s);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic        pop = 1'b0;
	logic        total_size_we = 1'b0;
	logic [31:0] total_size = 32'h0;
	logic        full;
	logic        empty;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        stream_done;

	decode_scoreboard sb = new();
	int            send_idle = 7;
	int            recv_idle = 50;
	int            sent = 0;
	int            quiet = 0;
	int            stall_req = 0;
	bit            plan_bits[$];
	logic [WB-1:0] plan_wr = WB'(FILL_END);

	lzss_bit_decoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.stream_done  (stream_done),
		.total_size_we(total_size_we),
		.total_size   (total_size)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WD_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// output side; a long hold-off is taken when the main flow asks for it
	initial begin
		int stall_done;
		stall_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.match_output(out_byte, run_last, stream_done);
			if (stall_req != stall_done) begin
				stall_done = stall_req;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (full !== 1'b0) @(posedge clk);
		sb.decode_byte(b);
		sent++;
	endtask

	task automatic put_bits(input logic [15:0] v, input int w);
		for (int i = w - 1; i >= 0; i--) begin
			plan_bits.push_back(v[i]);
		end
	endtask

	task automatic add_literal(input logic [7:0] b);
		put_bits(16'd1, 1);
		put_bits({8'h00, b}, 8);
		plan_wr = plan_wr + 1'b1;
	endtask

	task automatic add_match(input logic [WB-1:0] p, input logic [LB-1:0] lenf);
		put_bits(16'd0, 1);
		put_bits(16'(p), WB);
		put_bits(16'(lenf), LB);
		plan_wr = plan_wr + lenf + 2'd2;
	endtask

	task automatic flush_bytes();
		logic [7:0] b;
		while (plan_bits.size() >= 8) begin
			for (int i = 7; i >= 0; i--) begin
				b[i] = plan_bits.pop_front();
			end
			send_byte(b);
		end
	endtask

	task automatic add_random_token();
		int            r;
		int            sel;
		logic [WB-1:0] p;
		logic [LB-1:0] lenf;
		r = $urandom_range(99);
		sel = $urandom_range(9);
		if (r < 45) begin
			add_literal(8'($urandom_range(255)));
		end else if (r < 90) begin
			if (sel < 5)
				p = WB'(plan_wr - 1 - $urandom_range(30));
			else if (sel < 7)
				p = WB'($urandom_range(RING - 1));
			else
				p = WB'(FILL_END + $urandom_range(16));
			lenf = ($urandom_range(9) == 0) ? 4'hF : LB'($urandom_range(15));
			add_match(p, lenf);
		end else begin
			put_bits(16'($urandom_range(255)), 8);
		end
	endtask

	task automatic run_random(input int n);
		int target;
		target = sent + n;
		while (sent < target) begin
			add_random_token();
			flush_bytes();
		end
	endtask

	// sender pauses until every decoded byte is out and the core has gone quiet
	task automatic drain();
		push <= 1'b0;
		while (sb.pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_total(input logic [31:0] v);
		total_size_we <= 1'b1;
		total_size <= v;
		@(posedge clk);
		total_size_we <= 1'b0;
		sb.set_total(v);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (full !== 1'b0) @(posedge clk);

		write_total(32'hFFFF_FFFF);
		send_idle = 7;
		recv_idle = 50;
		add_match(9'(FILL_END + 5), 4'hF);
		add_literal(8'h00);
		add_literal(8'hFF);
		add_match(9'd0, 4'h0);
		add_match(9'(RING - 1), 4'hF);
		add_match(plan_wr - 1'b1, 4'hF);
		add_match(plan_wr - 2'd3, 4'h4);
		add_literal(8'hA5);
		add_literal(8'h5A);
		add_match(9'(FILL_END), 4'h7);
		put_bits(16'h00FF, 8);
		put_bits(16'h00FF, 8);
		put_bits(16'h0000, 8);
		put_bits(16'h0000, 8);
		flush_bytes();
		run_random(30);
		stall_req <= stall_req + 1;
		run_random(40);
		drain();

		write_total($urandom_range(32'hFFFF_FFFE, 32'h0100_0000));
		send_idle = 50;
		recv_idle = 7;
		run_random(70);
		drain();

		// stream runs into its size limit, usually part-way through a copy
		write_total(sb.emitted + $urandom_range(250, 150));
		send_idle = 0;
		recv_idle = 0;
		while (!sb.done) begin
			add_random_token();
			flush_bytes();
		end
		repeat (4) send_byte(8'($urandom_range(255)));
		drain();

		write_total(32'h0);
		repeat (3) send_byte(8'($urandom_range(255)));
		drain();
		write_total(32'hFFFF_FFFF);
		repeat (3) send_byte(8'($urandom_range(255)));
		drain();

		if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
